// ===== sv/sgcs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sgcs_pkg;

   localparam int unsigned SizeW  = 8;
   localparam int unsigned SpeedW = 24;
   localparam int unsigned TickW  = 32;
   localparam int unsigned PosW   = 16;
   localparam int unsigned CsrIdxW = 3;
   localparam int unsigned CsrDataW = 32;

   // shared arithmetic widths
   localparam int unsigned MulAW = 26;
   localparam int unsigned MulBW = 18;
   localparam int unsigned MulPW = MulAW + MulBW;
   localparam int unsigned SubW  = 34;

   localparam logic [SpeedW-1:0] SPEED_MAX = '1;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_BASE_SIZE   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_MAX_SIZE    = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_MIN_SPEED   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_MAX_SPEED   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_REV_THRESH  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_QUIET_TICKS = 3'd5;

   localparam logic [SizeW-1:0]  RST_BASE_SIZE   = 8'd32;
   localparam logic [SizeW-1:0]  RST_MAX_SIZE    = 8'd128;
   localparam logic [SpeedW-1:0] RST_MIN_SPEED   = 24'd256;
   localparam logic [SpeedW-1:0] RST_MAX_SPEED   = 24'd2560;
   localparam logic [SizeW-1:0]  RST_REV_THRESH  = 8'd4;
   localparam logic [TickW-1:0]  RST_QUIET_TICKS = 32'd1000;
   localparam logic [SizeW-1:0]  RST_SIZE_NOW    = 8'd32;

endpackage
`default_nettype wire

// ===== sv/sgcs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sgcs_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sgcs_pkg::PosW-1:0]       pos_x;
   logic signed [sgcs_pkg::PosW-1:0]       pos_y;
   logic        [sgcs_pkg::TickW-1:0]      timestamp;
   modport source (output valid, pos_x, pos_y, timestamp, input ready);
   modport sink   (input valid, pos_x, pos_y, timestamp, output ready);
endinterface

interface sgcs_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [sgcs_pkg::SizeW-1:0]             cursor_size;
   logic                                   size_written;
   logic                                   shake_active;
   modport source (output valid, cursor_size, size_written, shake_active, input ready);
   modport sink   (input valid, cursor_size, size_written, shake_active, output ready);
endinterface
`default_nettype wire

// ===== sv/sgcs_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sgcs_mul (
   input  wire logic                                clock,
   input  wire logic signed [sgcs_pkg::MulAW-1:0]   a,
   input  wire logic signed [sgcs_pkg::MulBW-1:0]   b,
   output      logic signed [sgcs_pkg::MulPW-1:0]   p_ff
);
   logic signed [sgcs_pkg::MulPW-1:0] p_in;

   assign p_in = a * b;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
endmodule
`default_nettype wire

// ===== sv/sgcs_csub.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sgcs_csub (
   input  wire logic [sgcs_pkg::SubW-1:0] a,
   input  wire logic [sgcs_pkg::SubW-1:0] b,
   output      logic                      ge,
   output      logic [sgcs_pkg::SubW-1:0] diff
);
   logic [sgcs_pkg::SubW:0] wide;

   assign wide = {1'b0, a} - {1'b0, b};
   assign ge   = ~wide[sgcs_pkg::SubW];
   assign diff = wide[sgcs_pkg::SubW-1:0];
endmodule
`default_nettype wire

// ===== sv/shake_gesture_cursor_sizer_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | payload                                   | handshake
// req     | in  | pos_x, pos_y, timestamp                   | valid/ready
// rsp     | out | cursor_size, size_written, shake_active   | valid/ready
// csr     | in  | csr_index, csr_wdata                      | csr_we, no wait
// A request is served by one shared compare/subtract unit (25 square root steps,
// 25 speed divide steps, 8 size divide steps) and one shared registered multiplier;
// the compare/subtract steps run only in shake mode.
// Reset is synchronous; no clearing pass. One request is in work at a time;
// the next is taken while a finished result still waits in the rsp register.
module shake_gesture_cursor_sizer_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sgcs_req_if.sink                               req,
   sgcs_rsp_if.source                             rsp,
   input  wire logic                              csr_we,
   input  wire logic [sgcs_pkg::CsrIdxW-1:0]      csr_index,
   input  wire logic [sgcs_pkg::CsrDataW-1:0]     csr_wdata
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL  = 4'd1;
   localparam logic [3:0] S_EVAL = 4'd2;
   localparam logic [3:0] S_SQRT = 4'd3;
   localparam logic [3:0] S_SPD  = 4'd4;
   localparam logic [3:0] S_TGT  = 4'd5;
   localparam logic [3:0] S_TMAG = 4'd6;
   localparam logic [3:0] S_TDIV = 4'd7;
   localparam logic [3:0] S_STEP = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   function automatic logic [7:0] div5(input logic [8:0] v);
      logic [17:0] prod;
      prod = {9'd0, v} * 18'd205;
      return prod[17:10];
   endfunction

   // configuration
   logic [7:0]  base_ff, base_in, maxs_ff, maxs_in, thr_ff, thr_in;
   logic [23:0] mins_ff, mins_in, maxsp_ff, maxsp_in;
   logic [31:0] quiet_ff, quiet_in;

   // persistent state
   logic signed [15:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic signed [15:0] ox0_ff, ox0_in, ox1_ff, ox1_in, oy0_ff, oy0_in, oy1_ff, oy1_in;
   logic [1:0]  fill_ff, fill_in;
   logic [7:0]  count_ff, count_in, size_ff, size_in;
   logic        shake_ff, shake_in;
   logic [31:0] ltick_ff, ltick_in, rtick_ff, rtick_in;

   // working registers
   logic [3:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic signed [15:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] now_ff, now_in;
   logic [33:0] d2_ff, d2_in;
   logic signed [34:0] dot_ff, dot_in;
   logic        rev_ff, rev_in, shk_ff, shk_in, wr_ff, wr_in, neg_ff, neg_in;
   logic [7:0]  cntw_ff, cntw_in, sizew_ff, sizew_in;
   logic [23:0] speed_ff, speed_in;
   logic signed [9:0] tgt_ff, tgt_in;
   logic [32:0] rem_ff, rem_in;
   logic [49:0] shr_ff, shr_in;
   logic [24:0] q_ff, q_in;

   // result register
   logic        rvalid_ff, rvalid_in, rwr_ff, rwr_in, rshk_ff, rshk_in;
   logic [7:0]  rsize_ff, rsize_in;

   // shared units
   logic signed [sgcs_pkg::MulAW-1:0] mul_a;
   logic signed [sgcs_pkg::MulBW-1:0] mul_b;
   logic signed [sgcs_pkg::MulPW-1:0] mul_p;
   logic [sgcs_pkg::SubW-1:0]         sub_a, sub_b, sub_d;
   logic                              sub_ge;

   sgcs_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p_ff(mul_p));
   sgcs_csub u_csub (.a(sub_a), .b(sub_b), .ge(sub_ge), .diff(sub_d));

   logic signed [16:0] dx, dy, ax, ay, bx, by;
   logic [31:0] elapsed;
   logic [24:0] q_next;

   assign dx = 17'(x_ff) - 17'(last_x_ff);
   assign dy = 17'(y_ff) - 17'(last_y_ff);
   assign ax = 17'(ox1_ff) - 17'(ox0_ff);
   assign ay = 17'(oy1_ff) - 17'(oy0_ff);
   assign bx = 17'(x_ff) - 17'(ox0_ff);
   assign by = 17'(y_ff) - 17'(oy0_ff);
   assign elapsed = now_ff - ltick_ff;
   assign q_next = {q_ff[23:0], sub_ge};

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rvalid_ff;
   assign rsp.cursor_size = rsize_ff;
   assign rsp.size_written = rwr_ff;
   assign rsp.shake_active = rshk_ff;

   // operand select for the shared units
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cnt_ff[1:0])
         2'd0: begin mul_a = 26'(dx); mul_b = 18'(dx); end
         2'd1: begin mul_a = 26'(dy); mul_b = 18'(dy); end
         2'd2: begin mul_a = 26'(ax); mul_b = 18'(bx); end
         default: begin mul_a = 26'(ay); mul_b = 18'(by); end
      endcase
      if (state_ff == S_TGT) begin
         mul_a = $signed({2'b00, speed_ff - mins_ff});
         mul_b = 18'($signed({1'b0, maxs_ff}) - $signed({1'b0, base_ff}));
      end
      sub_a = {rem_ff, shr_ff[49]};
      sub_b = {10'd0, maxsp_ff - mins_ff};
      case (state_ff)
         S_SQRT: begin
            sub_a = {rem_ff[31:0], shr_ff[49:48]};
            sub_b = {7'd0, q_ff, 2'b01};
         end
         S_SPD: sub_b = {2'd0, elapsed};
         default: ;
      endcase
   end

   always_comb begin
      logic rev, legs, quiet;
      logic [7:0] cn;
      logic [31:0] rt;
      logic signed [43:0] pm;
      logic [31:0] mag;
      logic signed [9:0] cur, nxt, bs, mx;
      logic [8:0] dd;

      base_in = base_ff; maxs_in = maxs_ff; thr_in = thr_ff;
      mins_in = mins_ff; maxsp_in = maxsp_ff; quiet_in = quiet_ff;
      last_x_in = last_x_ff; last_y_in = last_y_ff;
      ox0_in = ox0_ff; ox1_in = ox1_ff; oy0_in = oy0_ff; oy1_in = oy1_ff;
      fill_in = fill_ff; count_in = count_ff; size_in = size_ff; shake_in = shake_ff;
      ltick_in = ltick_ff; rtick_in = rtick_ff;
      state_in = state_ff; cnt_in = cnt_ff;
      x_in = x_ff; y_in = y_ff; now_in = now_ff;
      d2_in = d2_ff; dot_in = dot_ff;
      rev_in = rev_ff; shk_in = shk_ff; wr_in = wr_ff; neg_in = neg_ff;
      cntw_in = cntw_ff; sizew_in = sizew_ff; speed_in = speed_ff; tgt_in = tgt_ff;
      rem_in = rem_ff; shr_in = shr_ff; q_in = q_ff;
      rvalid_in = rvalid_ff; rwr_in = rwr_ff; rshk_in = rshk_ff; rsize_in = rsize_ff;

      rev = 1'b0; legs = 1'b0; quiet = 1'b0; cn = '0; rt = '0; pm = '0; mag = '0;
      cur = '0; nxt = '0; bs = '0; mx = '0; dd = '0;

      if (rvalid_ff && rsp.ready) rvalid_in = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            sgcs_pkg::CSR_BASE_SIZE:   base_in  = csr_wdata[7:0];
            sgcs_pkg::CSR_MAX_SIZE:    maxs_in  = csr_wdata[7:0];
            sgcs_pkg::CSR_MIN_SPEED:   mins_in  = csr_wdata[23:0];
            sgcs_pkg::CSR_MAX_SPEED:   maxsp_in = csr_wdata[23:0];
            sgcs_pkg::CSR_REV_THRESH:  thr_in   = csr_wdata[7:0];
            sgcs_pkg::CSR_QUIET_TICKS: quiet_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               x_in = req.pos_x;
               y_in = req.pos_y;
               now_in = req.timestamp;
               cnt_in = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            pm = mul_p;
            case (cnt_ff)
               5'd1: d2_in = pm[33:0];
               5'd2: d2_in = d2_ff + pm[33:0];
               5'd3: dot_in = pm[34:0];
               5'd4: dot_in = dot_ff + pm[34:0];
               default: ;
            endcase
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd4) state_in = S_EVAL;
         end
         S_EVAL: begin
            legs = (ax != 0 || ay != 0) && (bx != 0 || by != 0);
            rev = (fill_ff >= 2'd2) && legs && (dot_ff <= 0);
            cn = (rev && count_ff != 8'd255) ? count_ff + 8'd1 : count_ff;
            rev_in = rev;
            cntw_in = cn;
            shk_in = shake_ff | (rev && cn >= thr_ff);
            wr_in = 1'b0;
            cnt_in = '0;
            rem_in = '0;
            q_in = '0;
            shr_in = {d2_ff, 16'd0};
            if (!(shake_ff | (rev && cn >= thr_ff))) begin
               state_in = S_DONE;
            end else if (elapsed == 0) begin
               speed_in = sgcs_pkg::SPEED_MAX;
               state_in = S_TGT;
            end else begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            rem_in = sub_ge ? sub_d[32:0] : sub_a[32:0];
            q_in = q_next;
            shr_in = {shr_ff[47:0], 2'b00};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd24) begin
               // hand the root to the speed divide as its dividend
               shr_in = {q_next, 25'd0};
               rem_in = '0;
               q_in = '0;
               cnt_in = '0;
               state_in = S_SPD;
            end
         end
         S_SPD: begin
            rem_in = sub_ge ? sub_d[32:0] : sub_a[32:0];
            q_in = q_next;
            shr_in = {shr_ff[48:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd24) begin
               speed_in = q_next[24] ? sgcs_pkg::SPEED_MAX : q_next[23:0];
               state_in = S_TGT;
            end
         end
         S_TGT: begin
            if (speed_ff < mins_ff) begin
               tgt_in = {2'b00, base_ff};
               state_in = S_STEP;
            end else if (speed_ff > maxsp_ff) begin
               tgt_in = {2'b00, maxs_ff};
               state_in = S_STEP;
            end else if (maxsp_ff == mins_ff) begin
               tgt_in = {2'b00, base_ff};
               state_in = S_STEP;
            end else begin
               state_in = S_TMAG;
            end
         end
         S_TMAG: begin
            pm = mul_p;
            neg_in = pm[43];
            mag = pm[43] ? 32'(-pm) : pm[31:0];
            rem_in = {9'd0, mag[31:8]};
            shr_in = {mag[7:0], 42'd0};
            q_in = '0;
            cnt_in = '0;
            state_in = S_TDIV;
         end
         S_TDIV: begin
            rem_in = sub_ge ? sub_d[32:0] : sub_a[32:0];
            q_in = q_next;
            shr_in = {shr_ff[48:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd7) begin
               tgt_in = neg_ff ? $signed({2'b00, base_ff}) - $signed({2'b00, q_next[7:0]})
                               : $signed({2'b00, base_ff}) + $signed({2'b00, q_next[7:0]});
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            cur = {2'b00, size_ff};
            bs = {2'b00, base_ff};
            mx = {2'b00, maxs_ff};
            nxt = cur;
            if (cur < tgt_ff) begin
               dd = 9'(tgt_ff - cur);
               nxt = cur + $signed({2'b00, div5(dd)});
            end else if (cur > tgt_ff) begin
               dd = 9'(cur - tgt_ff + 10'sd4);
               nxt = cur - $signed({2'b00, div5(dd)});
            end
            if (nxt < bs) nxt = bs;
            else if (nxt > mx) nxt = mx;
            sizew_in = nxt[7:0];
            wr_in = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            // commit only when the result register is free
            if (!rvalid_ff || rsp.ready) begin
               rt = rev_ff ? now_ff : rtick_ff;
               quiet = (now_ff - rt) > quiet_ff;
               rtick_in = rt;
               ltick_in = now_ff;
               count_in = quiet ? 8'd0 : cntw_ff;
               shake_in = quiet ? 1'b0 : shk_ff;
               if (wr_ff) size_in = sizew_ff;
               if (fill_ff >= 2'd2) begin
                  ox0_in = ox1_ff; oy0_in = oy1_ff;
                  ox1_in = x_ff;   oy1_in = y_ff;
               end else begin
                  if (fill_ff[0]) begin
                     ox1_in = x_ff; oy1_in = y_ff;
                  end else begin
                     ox0_in = x_ff; oy0_in = y_ff;
                  end
                  fill_in = fill_ff + 2'd1;
               end
               last_x_in = x_ff;
               last_y_in = y_ff;
               rvalid_in = 1'b1;
               rsize_in = wr_ff ? sizew_ff : size_ff;
               rwr_in = wr_ff;
               rshk_in = quiet ? 1'b0 : shk_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= sgcs_pkg::RST_BASE_SIZE;
         maxs_ff <= sgcs_pkg::RST_MAX_SIZE;
         mins_ff <= sgcs_pkg::RST_MIN_SPEED;
         maxsp_ff <= sgcs_pkg::RST_MAX_SPEED;
         thr_ff <= sgcs_pkg::RST_REV_THRESH;
         quiet_ff <= sgcs_pkg::RST_QUIET_TICKS;
         last_x_ff <= '0; last_y_ff <= '0;
         ox0_ff <= '0; ox1_ff <= '0; oy0_ff <= '0; oy1_ff <= '0;
         fill_ff <= '0; count_ff <= '0; shake_ff <= 1'b0;
         size_ff <= sgcs_pkg::RST_SIZE_NOW;
         ltick_ff <= '0; rtick_ff <= '0;
         state_ff <= S_IDLE; cnt_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         base_ff <= base_in; maxs_ff <= maxs_in; mins_ff <= mins_in;
         maxsp_ff <= maxsp_in; thr_ff <= thr_in; quiet_ff <= quiet_in;
         last_x_ff <= last_x_in; last_y_ff <= last_y_in;
         ox0_ff <= ox0_in; ox1_ff <= ox1_in; oy0_ff <= oy0_in; oy1_ff <= oy1_in;
         fill_ff <= fill_in; count_ff <= count_in; shake_ff <= shake_in;
         size_ff <= size_in;
         ltick_ff <= ltick_in; rtick_ff <= rtick_in;
         state_ff <= state_in; cnt_ff <= cnt_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; now_ff <= now_in;
      d2_ff <= d2_in; dot_ff <= dot_in;
      rev_ff <= rev_in; shk_ff <= shk_in; wr_ff <= wr_in; neg_ff <= neg_in;
      cntw_ff <= cntw_in; sizew_ff <= sizew_in; speed_ff <= speed_in; tgt_ff <= tgt_in;
      rem_ff <= rem_in; shr_ff <= shr_in; q_ff <= q_in;
      rwr_ff <= rwr_in; rshk_ff <= rshk_in; rsize_ff <= rsize_in;
   end
endmodule
`default_nettype wire

// ===== dv/cursor_size_checker.sv =====
`timescale 1ns / 1ps
module cursor_size_checker
   import sgcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   sgcs_req_if                 req,
   sgcs_rsp_if                 rsp,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   output int                  mismatches,
   output int                  awaiting
);

   typedef struct packed {
      logic [SizeW-1:0] size;
      logic             written;
      logic             shake;
   } sizer_out_type;

   sizer_out_type size_q[$];

   // register copies
   logic [SizeW-1:0]  base_sz, top_sz, rev_thresh;
   logic [SpeedW-1:0] lo_speed, hi_speed;
   logic [TickW-1:0]  quiet;

   // gesture state
   logic signed [PosW-1:0] prev_x, prev_y;
   logic signed [PosW-1:0] hist_x[2], hist_y[2];
   int unsigned            hist_n;
   logic [7:0]             rev_count;
   logic                   shaking;
   logic [SizeW-1:0]       held_size;
   logic [TickW-1:0]       move_tick, rev_tick;

   initial begin
      mismatches = 0;
      awaiting   = 0;
   end

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root = 0;
      longint unsigned bitv = 64'h1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   task automatic report(string field, longint got, longint want);
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, field, got, want);
      mismatches++;
   endtask

   function automatic sizer_out_type predict_size(logic signed [PosW-1:0] x,
                                                  logic signed [PosW-1:0] y,
                                                  logic [TickW-1:0] now);
      longint          dx, dy, ax, ay, bx, by, tgt, cur, num;
      longint unsigned dist_q8, speed;
      logic [TickW-1:0] elapsed;
      logic            wr;
      sizer_out_type   res;
      dx = longint'(x) - longint'(prev_x);
      dy = longint'(y) - longint'(prev_y);
      dist_q8 = int_sqrt(longint'(dx * dx + dy * dy) << 16);
      elapsed = now - move_tick;
      wr = 1'b0;
      move_tick = now;
      if (hist_n >= 2) begin
         ax = longint'(hist_x[1]) - longint'(hist_x[0]);
         ay = longint'(hist_y[1]) - longint'(hist_y[0]);
         bx = longint'(x) - longint'(hist_x[0]);
         by = longint'(y) - longint'(hist_y[0]);
         // both legs must be nonzero for a reversal
         if ((ax != 0 || ay != 0) && (bx != 0 || by != 0) && ax * bx + ay * by <= 0) begin
            if (rev_count != 8'hFF) rev_count++;
            rev_tick = now;
            if (rev_count >= rev_thresh) shaking = 1'b1;
         end
         hist_x[0] = hist_x[1];
         hist_y[0] = hist_y[1];
         hist_x[1] = x;
         hist_y[1] = y;
      end else begin
         hist_x[hist_n] = x;
         hist_y[hist_n] = y;
         hist_n++;
      end
      if (shaking) begin
         cur = longint'(held_size);
         if (elapsed == 0) speed = SPEED_MAX;
         else begin
            speed = dist_q8 / elapsed;
            if (speed > SPEED_MAX) speed = SPEED_MAX;
         end
         if (speed < lo_speed) tgt = base_sz;
         else if (speed > hi_speed) tgt = top_sz;
         else if (hi_speed == lo_speed) tgt = base_sz;
         else begin
            num = (longint'(top_sz) - longint'(base_sz)) *
                  (longint'(speed) - longint'(lo_speed));
            tgt = longint'(base_sz) + num / (longint'(hi_speed) - longint'(lo_speed));
         end
         if (cur < tgt) cur = cur + (tgt - cur) / 5;
         else if (cur > tgt) cur = cur - (cur - tgt + 4) / 5;
         if (cur < longint'(base_sz)) cur = base_sz;
         else if (cur > longint'(top_sz)) cur = top_sz;
         held_size = cur[SizeW-1:0];
         wr = 1'b1;
      end
      if (now - rev_tick > quiet) begin
         rev_count = '0;
         shaking   = 1'b0;
      end
      prev_x = x;
      prev_y = y;
      res.size    = held_size;
      res.written = wr;
      res.shake   = shaking;
      return res;
   endfunction

   always @(posedge clock) begin
      sizer_out_type want;
      if (reset) begin
         base_sz = RST_BASE_SIZE;   top_sz = RST_MAX_SIZE;
         lo_speed = RST_MIN_SPEED;  hi_speed = RST_MAX_SPEED;
         rev_thresh = RST_REV_THRESH; quiet = RST_QUIET_TICKS;
         prev_x = '0; prev_y = '0;
         hist_x[0] = '0; hist_x[1] = '0; hist_y[0] = '0; hist_y[1] = '0;
         hist_n = 0; rev_count = '0; shaking = 1'b0;
         held_size = RST_SIZE_NOW; move_tick = '0; rev_tick = '0;
         size_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BASE_SIZE:   base_sz    = csr_wdata[SizeW-1:0];
               CSR_MAX_SIZE:    top_sz     = csr_wdata[SizeW-1:0];
               CSR_MIN_SPEED:   lo_speed   = csr_wdata[SpeedW-1:0];
               CSR_MAX_SPEED:   hi_speed   = csr_wdata[SpeedW-1:0];
               CSR_REV_THRESH:  rev_thresh = csr_wdata[SizeW-1:0];
               CSR_QUIET_TICKS: quiet      = csr_wdata[TickW-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready)
            size_q.insert(size_q.size(), predict_size(req.pos_x, req.pos_y, req.timestamp));
         if (rsp.valid && rsp.ready) begin
            if (size_q.size() == 0) begin
               report("unexpected response", rsp.cursor_size, -1);
            end else begin
               want = size_q.pop_front();
               if (rsp.cursor_size !== want.size)
                  report("cursor_size", rsp.cursor_size, want.size);
               if (rsp.size_written !== want.written)
                  report("size_written", rsp.size_written, want.written);
               if (rsp.shake_active !== want.shake)
                  report("shake_active", rsp.shake_active, want.shake);
            end
         end
      end
      awaiting = size_q.size();
   end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
   import sgcs_pkg::*;

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CsrIdxW-1:0]  csr_index;
   logic [CsrDataW-1:0] csr_wdata;
   int                  mismatches;
   int                  awaiting;

   sgcs_req_if req_ch ();
   sgcs_rsp_if rsp_ch ();

   shake_gesture_cursor_sizer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cursor_size_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .awaiting   (awaiting)
   );

   // zigzag walk state
   int               walk_x, walk_y, walk_sign;
   logic [TickW-1:0] tick;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 120);
   endfunction

   // response side stalls
   initial begin
      int g;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         g = pick_gap();
         if (g > 0) begin
            repeat ($urandom_range(1, 40)) @(negedge clock);
            rsp_ch.ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
      end
   end

   task automatic send_move(int x, int y, logic [TickW-1:0] t);
      int g;
      g = pick_gap();
      @(negedge clock);
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.pos_x     <= x[PosW-1:0];
      req_ch.pos_y     <= y[PosW-1:0];
      req_ch.timestamp <= t;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_reg(logic [CsrIdxW-1:0] idx, logic [CsrDataW-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      csr_we       <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic set_all(int bsz, int msz, int lo, int hi, int thr, logic [31:0] q);
      write_reg(CSR_BASE_SIZE, bsz);
      write_reg(CSR_MAX_SIZE, msz);
      write_reg(CSR_MIN_SPEED, lo);
      write_reg(CSR_MAX_SPEED, hi);
      write_reg(CSR_REV_THRESH, thr);
      write_reg(CSR_QUIET_TICKS, q);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_move();
      int r, amp, x, y;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         amp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, 12);
         walk_sign = -walk_sign;
         if ($urandom_range(0, 19) == 0) begin
            walk_x = $urandom_range(0, 60000) - 30000;
            walk_y = $urandom_range(0, 60000) - 30000;
         end
         x = walk_x + walk_sign * amp;
         y = walk_y + walk_sign * $urandom_range(0, 3) - $urandom_range(0, 1);
      end else begin
         x = $urandom;
         y = $urandom;
      end
      r = $urandom_range(0, 99);
      if (r < 5) ;
      else if (r < 90) tick += $urandom_range(1, 30);
      else if (r < 97) tick += $urandom_range(100, 5000);
      else tick = $urandom;
      send_move(x, y, tick);
   endtask

   initial begin
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_ch.valid = 1'b0;
      req_ch.pos_x = '0;
      req_ch.pos_y = '0;
      req_ch.timestamp = '0;
      walk_x = 0; walk_y = 0; walk_sign = 1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, zero elapsed, degenerate legs, wrap, quiet clear
      send_move(0, 0, 0);
      send_move(32767, -32768, 5);
      send_move(-32768, 32767, 6);
      send_move(-32768, 32767, 6);
      send_move(100, 100, 10);
      send_move(105, 100, 12);
      send_move(96, 100, 14);
      send_move(108, 100, 16);
      send_move(93, 100, 18);
      send_move(111, 100, 19);
      send_move(90, 100, 19);
      send_move(114, 100, 32'hFFFF_FFFF);
      send_move(88, 100, 3);
      send_move(116, 101, 4);
      send_move(0, 0, 32'h8000_0000);
      settle();
      set_all(20, 200, 100, 100, 0, 32'hFFFF_FFFF);
      send_move(10, 10, 100);
      send_move(12, 10, 101);
      send_move(9, 10, 102);
      send_move(13, 10, 103);
      send_move(32767, 32767, 104);
      settle();
      tick = 200;

      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: ;
            1: set_all(16, 200, 128, 4096, 3, 500);
            2: set_all(0, 255, 0, 24'hFF_FFFF, 1, 32'hFFFF_FFFF);
            3: set_all(255, 0, 5000, 100, 255, 0);
            4: set_all(40, 40, 1000, 1000, 0, 50);
            5: set_all($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 4000), $urandom_range(0, 24'hFF_FFFF),
                       $urandom_range(1, 255), $urandom);
            default: set_all(10, 250, 256, 1280, 2, 2000);
         endcase
         repeat (150) random_move();
         settle();
      end

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/sgcs_pkg.sv
sv/sgcs_if.sv
sv/sgcs_mul.sv
sv/sgcs_csub.sv
sv/shake_gesture_cursor_sizer_top.sv
dv/cursor_size_checker.sv
dv/testbench.sv
